// File: hdl/mie_pkg.sv
// Shared types and constants for the mnemonic index encoder.
// SHA-256 round constants, initial hash value, a rotate helper and the FSM type.
// No dependencies.
package mie_pkg;

    localparam int WORD_BITS  = 11;
    localparam int CHUNK_BITS = 32;
    localparam int CSUM_BITS  = 8;

    localparam logic [1:0] MODE_128    = 2'd0;
    localparam logic [1:0] MODE_192    = 2'd1;
    localparam logic [1:0] MODE_256    = 2'd2;
    // unused code, behaves as the 256-bit mode
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [3:0] CHUNKS_128 = 4'd4;
    localparam logic [3:0] CHUNKS_192 = 4'd6;
    localparam logic [3:0] CHUNKS_256 = 4'd8;

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_EMIT
    } t_state;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: hdl/mie_if.sv
// Valid/ready channel interfaces for entropy chunks in and word indices out.
// Depends on nothing.
interface mie_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] entropy_chunk;
    modport source (output valid, output entropy_chunk, input ready);
    modport sink   (input valid, input entropy_chunk, output ready);
endinterface

interface mie_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] word_index;
    logic        word_last;
    modport source (output valid, output word_index, output word_last, input ready);
    modport sink   (input valid, input word_index, input word_last, output ready);
endinterface

// File: hdl/mie_sha_core.sv
// Iterative SHA-256 compression: one round per cycle, rounds 0 to 63.
// Depends on mie_pkg; message words 0..15 come in from the caller.
module mie_sha_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_msg_word,
    output logic [5:0]  o_round,
    output logic        o_done,
    output logic [7:0]  o_csum
);
    import mie_pkg::*;

    logic [31:0] r_v [8];
    logic [31:0] n_v [8];
    logic [31:0] r_sched [16];
    logic [5:0]  r_round;
    logic        r_busy;
    logic        r_done;
    logic [31:0] w_t, s0, s1, bs0, bs1, ch, mj, t1, t2;
    logic [31:0] digest0;

    // message schedule word for this round
    always_comb begin
        s0 = rotr(r_sched[1], 7) ^ rotr(r_sched[1], 18) ^ (r_sched[1] >> 3);
        s1 = rotr(r_sched[14], 17) ^ rotr(r_sched[14], 19) ^ (r_sched[14] >> 10);
        if (r_round < 6'd16) begin
            w_t = i_msg_word;
        end else begin
            w_t = s1 + r_sched[9] + s0 + r_sched[0];
        end
    end

    // round function
    always_comb begin
        bs1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1  = r_v[7] + bs1 + ch + SHA_K[r_round] + w_t;
        bs0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        mj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2  = bs0 + mj;
        n_v[7] = r_v[6];
        n_v[6] = r_v[5];
        n_v[5] = r_v[4];
        n_v[4] = r_v[3] + t1;
        n_v[3] = r_v[2];
        n_v[2] = r_v[1];
        n_v[1] = r_v[0];
        n_v[0] = t1 + t2;
    end

    // working variables and schedule window
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int i = 0; i < 8; i++) r_v[i] <= SHA_IV[i];
        end else if (r_busy) begin
            for (int i = 0; i < 8; i++) r_v[i] <= n_v[i];
            for (int i = 0; i < 15; i++) r_sched[i] <= r_sched[i+1];
            r_sched[15] <= w_t;
        end
    end

    // round sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // only the top byte of the first digest word is used
    assign digest0 = SHA_IV[0] + r_v[0];
    assign o_csum  = digest0[31:24];
    assign o_done  = r_done;
    assign o_round = r_round;

endmodule

// File: hdl/mie_emit.sv
// Word emitter: packs entropy and checksum, shifts out 11-bit indices.
// Depends on mie_pkg and mie_out_if.
module mie_emit #(
    parameter int MAX_CHUNKS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [3:0]  i_need,
    input  logic [31:0] i_store [MAX_CHUNKS],
    input  logic [7:0]  i_csum,
    output logic        o_done,
    mie_out_if.source   o_out
);
    import mie_pkg::*;

    localparam int SRW = MAX_CHUNKS * CHUNK_BITS + CSUM_BITS;

    logic [SRW-1:0] r_sr;
    logic [SRW-1:0] packed_bits;
    logic [4:0]     r_cnt;
    logic           r_valid;
    logic           last;
    logic           take;

    // entropy chunks MSB first, checksum byte right after them
    always_comb begin
        packed_bits = '0;
        for (int i = 0; i < MAX_CHUNKS; i++) begin
            if (i < int'(i_need)) packed_bits[SRW-1-32*i -: 32] = i_store[i];
        end
        packed_bits[SRW-1-32*int'(i_need) -: 8] = i_csum;
    end

    assign last = (r_cnt == 5'(3 * int'(i_need) - 1));
    assign take = r_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sr <= packed_bits;
        end else if (take) begin
            r_sr <= r_sr << WORD_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_cnt   <= '0;
        end else if (take) begin
            r_cnt <= r_cnt + 5'd1;
            if (last) r_valid <= 1'b0;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.word_index = r_sr[SRW-1 -: WORD_BITS];
    assign o_out.word_last  = last;
    assign o_done           = take && last;

endmodule

// File: hdl/mnemonic_index_encoder_top.sv
// Top level of the mnemonic index encoder.
// Depends on mie_pkg, mie_if, mie_sha_core and mie_emit.
//
// Usage: entropy arrives on i_in as 32-bit words, most significant first.
// length_mode (i_cfg_wr_data, written when i_cfg_wr_en is high) picks
// 4, 6 or 8 words (code 3 acts as 8), capped at MAX_CHUNKS. Words before
// the last of a mnemonic are taken one per cycle while i_in.ready is high.
// The final word starts one SHA-256 compression in a single round unit,
// one round per cycle; the registered done flag then loads the emitter,
// whose first index is then valid. Then 12, 18 or 24 indices leave on
// o_out, one per cycle while the receiver is ready, last one flagged.
// i_in.ready is low from the final word until the last index is taken.
// A stalled receiver simply holds the current index in the output register.
// Reset (i_rst_n, synchronous) clears the word count, sets mode 0 and
// drops any mnemonic in flight.
module mnemonic_index_encoder_top #(
    parameter int MAX_CHUNKS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    mie_in_if.sink     i_in,
    mie_out_if.source  o_out
);
    import mie_pkg::*;

    localparam int IW = $clog2(MAX_CHUNKS);

    t_state      r_state, n_state;
    logic [1:0]  r_mode;
    logic [3:0]  r_count;
    logic [3:0]  r_need;
    logic [3:0]  need_now;
    logic [3:0]  n_count;
    logic [31:0] r_store [MAX_CHUNKS];
    logic [IW-1:0] wr_idx;
    logic        accept;
    logic        start;
    logic        hash_done;
    logic        emit_done;
    logic [5:0]  round;
    logic [3:0]  tt;
    logic [31:0] msg_word;
    logic [7:0]  csum;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_128;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // word count for the current mode, capped by storage
    always_comb begin
        unique case (r_mode)
            MODE_128: need_now = CHUNKS_128;
            MODE_192: need_now = CHUNKS_192;
            default:  need_now = CHUNKS_256;
        endcase
        if (int'(need_now) > MAX_CHUNKS) need_now = 4'(MAX_CHUNKS);
    end

    assign accept  = i_in.valid && i_in.ready;
    assign n_count = r_count + 4'd1;
    assign wr_idx  = (int'(r_count) < MAX_CHUNKS) ? r_count[IW-1:0] : IW'(MAX_CHUNKS - 1);
    assign start   = accept && (n_count >= need_now);

    // entropy storage
    always_ff @(posedge i_clk) begin
        if (accept) r_store[wr_idx] <= i_in.entropy_chunk;
        if (start) r_need <= need_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (start) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    // padded message word for the first sixteen rounds
    assign tt = round[3:0];
    always_comb begin
        if (tt < r_need) begin
            msg_word = r_store[tt[IW-1:0]];
        end else if (tt == r_need) begin
            msg_word = PAD_WORD;
        end else if (tt == 4'd15) begin
            msg_word = {23'd0, r_need, 5'd0};
        end else begin
            msg_word = '0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (start) n_state = ST_HASH;
            ST_HASH: if (hash_done) n_state = ST_EMIT;
            ST_EMIT: if (emit_done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = (r_state == ST_IDLE);
    end

    mie_sha_core u_sha (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_msg_word (msg_word),
        .o_round    (round),
        .o_done     (hash_done),
        .o_csum     (csum)
    );

    mie_emit #(.MAX_CHUNKS(MAX_CHUNKS)) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (hash_done),
        .i_need  (r_need),
        .i_store (r_store),
        .i_csum  (csum),
        .o_done  (emit_done),
        .o_out   (o_out)
    );

endmodule
